/* src/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int FIELD_W   = 64;
  localparam int DEF_WIDTH = 64;

  typedef struct packed {
    logic [FIELD_W-1:0] base_value;
    logic [FIELD_W-1:0] exponent_value;
    logic [FIELD_W-1:0] modulus_value;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] power_result;
    logic               bad_modulus;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new transaction
    logic red_step;  // one restoring-remainder step of the base reduction
    logic mul_start; // set up both shift-and-add products
    logic mul_step;  // one multiplier bit of both products
    logic mul_last;  // commit result, power and exponent with the last step
    logic out_load;  // move the finished result into the output register
  } mexp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_zero;
    logic expo_zero;
  } mexp_stat_t;

endpackage

/* src/mexp_ctrl.sv */
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for reduction, square-and-multiply and the output handshake.
// ----------------------------------------------------------------------------
module mexp_ctrl #(
  parameter int WIDTH = mexp_pkg::DEF_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  mexp_pkg::mexp_stat_t stat,
  output mexp_pkg::mexp_cmd_t  cmd
);

  localparam int CW = $clog2(WIDTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RED  = 5'b00010,
    S_CHK  = 5'b00100,
    S_MUL  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            last_step;
  logic            slot_free;
  logic            accept;

  assign last_step = (cnt_r == CW'(WIDTH - 1));
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        cmd.red_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (last_step) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cnt_nxt = '0;
        if (stat.mod_zero || stat.expo_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mul_start = 1'b1;
          state_nxt     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (last_step) begin
          cmd.mul_last = 1'b1;
          state_nxt    = S_CHK;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts_reduction: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_RED) && (cnt_r == '0))
    else $error("accepted transaction did not start the reduction");

  a_mul_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) && !stat.mod_zero && !stat.expo_zero |=>
      (state_r == S_MUL) && (cnt_r == '0))
    else $error("product steps did not start from a cleared count");

  a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && slot_free |=> out_valid_r && (state_r == S_IDLE))
    else $error("finished result was not presented");

  a_held_result_blocks_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !cmd.out_load)
    else $error("output register overwritten while stalled");

endmodule

/* src/mexp_dp.sv */
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: base reduction, two shift-and-add modular products, output register.
// ----------------------------------------------------------------------------
module mexp_dp #(
  parameter int WIDTH = mexp_pkg::DEF_WIDTH
) (
  input  logic                 clk,
  input  mexp_pkg::in_item_t   in_data,
  input  mexp_pkg::mexp_cmd_t  cmd,
  output mexp_pkg::mexp_stat_t stat,
  output mexp_pkg::out_item_t  out_data
);

  localparam int FW = mexp_pkg::FIELD_W;

  logic [WIDTH-1:0] mod_r;
  logic [WIDTH-1:0] base_r;
  logic [WIDTH-1:0] expo_r;
  logic [WIDTH-1:0] result_r;
  logic [WIDTH-1:0] power_r;
  logic [WIDTH-1:0] acc_a_r, add_a_r, x_a_r;
  logic [WIDTH-1:0] acc_b_r, add_b_r, x_b_r;
  logic             bad_r;
  mexp_pkg::out_item_t out_r;

  logic [WIDTH-1:0] in_mod;
  logic [WIDTH:0]   red_t;
  logic [WIDTH:0]   red_d;
  logic [WIDTH-1:0] red_nxt;
  logic [WIDTH-1:0] acc_a_nxt, add_a_nxt, acc_b_nxt, add_b_nxt;

  // (x + y) mod m for x, y below m.
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0] s;
    logic [WIDTH:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = s - {1'b0, m};
    add_mod = (s >= {1'b0, m}) ? d[WIDTH-1:0] : s[WIDTH-1:0];
  endfunction

  assign in_mod = in_data.modulus_value[WIDTH-1:0];

  // Restoring remainder: bring in one base bit per cycle, MSB first.
  assign red_t   = {power_r, base_r[WIDTH-1]};
  assign red_d   = red_t - {1'b0, mod_r};
  assign red_nxt = (red_t >= {1'b0, mod_r}) ? red_d[WIDTH-1:0] : red_t[WIDTH-1:0];

  assign acc_a_nxt = x_a_r[0] ? add_mod(acc_a_r, add_a_r, mod_r) : acc_a_r;
  assign add_a_nxt = add_mod(add_a_r, add_a_r, mod_r);
  assign acc_b_nxt = x_b_r[0] ? add_mod(acc_b_r, add_b_r, mod_r) : acc_b_r;
  assign add_b_nxt = add_mod(add_b_r, add_b_r, mod_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_r    <= in_mod;
      base_r   <= in_data.base_value[WIDTH-1:0];
      expo_r   <= in_data.exponent_value[WIDTH-1:0];
      result_r <= (in_mod == WIDTH'(1)) ? '0 : WIDTH'(1);
      power_r  <= '0;
      bad_r    <= (in_mod == '0);
    end
    if (cmd.red_step) begin
      power_r <= red_nxt;
      base_r  <= {base_r[WIDTH-2:0], 1'b0};
    end
    if (cmd.mul_start) begin
      acc_a_r <= '0;
      add_a_r <= power_r;
      x_a_r   <= result_r;
      acc_b_r <= '0;
      add_b_r <= power_r;
      x_b_r   <= power_r;
    end
    if (cmd.mul_step) begin
      acc_a_r <= acc_a_nxt;
      add_a_r <= add_a_nxt;
      x_a_r   <= x_a_r >> 1;
      acc_b_r <= acc_b_nxt;
      add_b_r <= add_b_nxt;
      x_b_r   <= x_b_r >> 1;
    end
    // The multiply only counts when the current exponent bit is set.
    if (cmd.mul_last) begin
      if (expo_r[0]) begin
        result_r <= acc_a_nxt;
      end
      power_r <= acc_b_nxt;
      expo_r  <= expo_r >> 1;
    end
    if (cmd.out_load) begin
      out_r.power_result <= bad_r ? '0 : FW'(result_r);
      out_r.bad_modulus  <= bad_r;
    end
  end

  assign stat.mod_zero  = bad_r;
  assign stat.expo_zero = (expo_r == '0);
  assign out_data       = out_r;

endmodule

/* src/modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base^exponent mod modulus by right-to-left square and multiply.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. After acceptance the base is reduced
// by a bit-serial remainder unit. Each exponent bit, up to the highest set one,
// then runs the product loop once: the square and the multiply run
// side by side as two shift-and-add modular products stepping one multiplier
// bit per cycle. A zero exponent or zero modulus skips the product loop. A zero
// modulus returns 0 with bad_modulus set. The next transaction may be accepted
// while a finished result is still stalled.
module modular_exponentiation #(
  parameter int WIDTH = mexp_pkg::DEF_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mexp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mexp_pkg::out_item_t out_data
);

  mexp_pkg::mexp_cmd_t  cmd;
  mexp_pkg::mexp_stat_t stat;

  mexp_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mexp_dp #(.WIDTH(WIDTH)) u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
